// File: rtl/shc_pkg.sv
// ----------------------------------------------------------------------------
// Shared-hit clustering package
// Types, state encodings and fixed widths shared by the clustering modules.
// ----------------------------------------------------------------------------
package shc_pkg;

    // Widths fixed by the transaction fields and by the parameter ranges.
    localparam int TRACK_W    = 16;
    localparam int HIT_W      = 16;
    localparam int CNT_MAX_W  = 9;   // holds a pending count of up to 256
    localparam int PADDR_MAX_W = 8;  // pending buffer index, up to 256 entries
    localparam int HADDR_MAX_W = 20; // hit table index, up to 2^20 entries

    // Event tag stored with every table entry; a tag that differs from the
    // current one marks the entry as not present in this event.
    localparam int EPOCH_BITS = 8;
    typedef logic [EPOCH_BITS-1:0] epoch_t;
    localparam epoch_t EPOCH_FIRST = epoch_t'(1);
    localparam epoch_t EPOCH_LAST  = '1;
    localparam epoch_t EPOCH_NONE  = '0;

    typedef enum logic [1:0] {
        F_CLEAR,
        F_IDLE,
        F_LOOK
    } front_state_t;

    typedef enum logic {
        B_IDLE,
        B_WRITE
    } back_state_t;

    // One classified track handed from the front to the back.
    typedef struct packed {
        logic [TRACK_W-1:0]   track;
        logic [TRACK_W-1:0]   leader;
        logic                 new_cluster;
        logic                 overflow;
        logic [CNT_MAX_W-1:0] count;
        epoch_t               epoch;
    } job_t;

    // Write port of the hit table.
    typedef struct packed {
        logic                   en;
        logic [HADDR_MAX_W-1:0] addr;
        epoch_t                 epoch;
        logic [TRACK_W-1:0]     leader;
    } tbl_wr_t;

    // Write port of the pending hit buffer.
    typedef struct packed {
        logic                   en;
        logic [PADDR_MAX_W-1:0] addr;
        logic [HADDR_MAX_W-1:0] hit;
    } pend_wr_t;

endpackage

// File: rtl/shc_if.sv
// ----------------------------------------------------------------------------
// Shared-hit clustering channels
// Valid/ready channels for hit transactions and cluster result transactions.
// ----------------------------------------------------------------------------
interface shc_hit_if;
    logic        valid;
    logic        ready;
    logic        new_event;
    logic [15:0] track_id;
    logic        has_hit;
    logic [15:0] hit_id;
    logic        last_hit;

    modport source (output valid, new_event, track_id, has_hit, hit_id, last_hit,
                    input ready);
    modport sink   (input valid, new_event, track_id, has_hit, hit_id, last_hit,
                    output ready);
endinterface

interface shc_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] track_id_out;
    logic [15:0] leader_id;
    logic        new_cluster;
    logic        overflow;

    modport source (output valid, track_id_out, leader_id, new_cluster, overflow,
                    input ready);
    modport sink   (input valid, track_id_out, leader_id, new_cluster, overflow,
                    output ready);
endinterface

// File: rtl/shc_table.sv
// ----------------------------------------------------------------------------
// Hit table
// Hit-to-leader memory with an event tag per entry, one read and one write
// port, registered read data.
// ----------------------------------------------------------------------------
module shc_table
    import shc_pkg::*;
#(
    parameter int HIT_ID_SPACE  = 65536,
    parameter int TRACK_ID_BITS = 16
)
(
    input  logic                            clk,
    input  tbl_wr_t                         clr_wr,
    input  tbl_wr_t                         upd_wr,
    input  logic                            rd_en,
    input  logic [$clog2(HIT_ID_SPACE)-1:0] rd_addr,
    output epoch_t                          rd_epoch,
    output logic [TRACK_W-1:0]              rd_leader
);
    localparam int HIDX_W = $clog2(HIT_ID_SPACE);
    localparam int LEAD_W = (TRACK_ID_BITS < TRACK_W) ? TRACK_ID_BITS : TRACK_W;

    logic [EPOCH_BITS+LEAD_W-1:0] mem [HIT_ID_SPACE];
    logic [EPOCH_BITS+LEAD_W-1:0] rd_reg;
    tbl_wr_t                      wr;

    // The clearing sweep and the cluster write-back never overlap.
    assign wr = clr_wr.en ? clr_wr : upd_wr;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[HIDX_W-1:0]] <= {wr.epoch, wr.leader[LEAD_W-1:0]};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_epoch  = rd_reg[EPOCH_BITS+LEAD_W-1:LEAD_W];
    assign rd_leader = TRACK_W'(rd_reg[LEAD_W-1:0]);
endmodule

// File: rtl/shc_queue.sv
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue of classified tracks between the front and the back.
// ----------------------------------------------------------------------------
module shc_queue
    import shc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic avail,
    output job_t head,
    input  logic pop
);
    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full  = (cnt_reg == 2'd2);
    assign avail = (cnt_reg != 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_next;
        end
    end
endmodule

// File: rtl/shc_front.sv
// ----------------------------------------------------------------------------
// Clustering front
// Accepts hit transactions, looks each hit up in the table, buffers the hits
// of an unmatched track and emits one classified job per track.
// ----------------------------------------------------------------------------
module shc_front
    import shc_pkg::*;
#(
    parameter int HIT_ID_SPACE  = 65536,
    parameter int MAX_HITS      = 32,
    parameter int TRACK_ID_BITS = 16
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    shc_hit_if.sink                         items,
    output logic                            tbl_rd_en,
    output logic [$clog2(HIT_ID_SPACE)-1:0] tbl_rd_addr,
    input  epoch_t                          tbl_rd_epoch,
    input  logic [TRACK_W-1:0]              tbl_rd_leader,
    output tbl_wr_t                         clr_wr,
    output pend_wr_t                        pend_wr,
    output logic                            push,
    output job_t                            push_job,
    input  logic                            q_full,
    input  logic                            wb_done
);
    localparam int HIDX_W = $clog2(HIT_ID_SPACE);
    localparam int LEAD_W = (TRACK_ID_BITS < TRACK_W) ? TRACK_ID_BITS : TRACK_W;
    localparam int CNT_W  = $clog2(MAX_HITS + 1);
    localparam int PIDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam logic [TRACK_W-1:0] TRACK_MASK = TRACK_W'((64'd1 << LEAD_W) - 64'd1);
    localparam logic [CNT_W-1:0]   CNT_FULL   = CNT_W'(MAX_HITS);

    front_state_t       state_reg, state_next;
    epoch_t             epoch_reg;
    logic               fresh_reg;
    logic [HIDX_W-1:0]  clr_addr_reg;
    logic [TRACK_W-1:0] it_track_reg;
    logic               it_has_reg;
    logic [HIDX_W-1:0]  it_idx_reg;
    logic               it_last_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               matched_reg, matched_next;
    logic [TRACK_W-1:0] mlead_reg, mlead_next;
    logic               ovf_reg, ovf_next;
    logic               wb_pend_reg;

    logic [HIDX_W-1:0]  in_idx;
    logic               wrap_block;
    logic               fire;
    logic               lookup;
    logic               known;
    logic               buf_hit;

    generate
        if (HIDX_W <= HIT_W)
        begin : g_idx_narrow
            assign in_idx = items.hit_id[HIDX_W-1:0];
        end
        else
        begin : g_idx_wide
            assign in_idx = HIDX_W'(items.hit_id);
        end
    endgenerate

    // A new event on the last tag needs a clearing sweep before it enters.
    assign wrap_block = items.new_event && (epoch_reg == EPOCH_LAST) && !fresh_reg;
    assign items.ready = (state_reg == F_IDLE) && !wb_pend_reg && !q_full && !wrap_block;
    assign fire = items.valid && items.ready;

    assign lookup  = it_has_reg && !matched_reg;
    assign known   = (tbl_rd_epoch == epoch_reg);
    assign buf_hit = lookup && !known && (cnt_reg < CNT_FULL);

    always_comb
    begin
        cnt_next     = cnt_reg + CNT_W'(buf_hit);
        matched_next = matched_reg || (lookup && known);
        mlead_next   = (lookup && known) ? tbl_rd_leader : mlead_reg;
        ovf_next     = ovf_reg || (lookup && !known && (cnt_reg >= CNT_FULL));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = F_IDLE;
                end
            end
            F_IDLE:
            begin
                if (fire)
                begin
                    state_next = F_LOOK;
                end
                else if (items.valid && wrap_block && !wb_pend_reg)
                begin
                    state_next = F_CLEAR;
                end
            end
            F_LOOK:
            begin
                state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        tbl_rd_en   = fire;
        tbl_rd_addr = in_idx;

        clr_wr.en     = (state_reg == F_CLEAR);
        clr_wr.addr   = HADDR_MAX_W'(clr_addr_reg);
        clr_wr.epoch  = EPOCH_NONE;
        clr_wr.leader = '0;

        pend_wr.en   = (state_reg == F_LOOK) && buf_hit;
        pend_wr.addr = PADDR_MAX_W'(cnt_reg[PIDX_W-1:0]);
        pend_wr.hit  = HADDR_MAX_W'(it_idx_reg);

        push                 = (state_reg == F_LOOK) && it_last_reg;
        push_job.track       = it_track_reg;
        push_job.leader      = matched_next ? mlead_next : it_track_reg;
        push_job.new_cluster = !matched_next;
        push_job.overflow    = ovf_next;
        push_job.count       = CNT_MAX_W'(cnt_next);
        push_job.epoch       = epoch_reg;
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            it_track_reg <= items.track_id & TRACK_MASK;
            it_has_reg   <= items.has_hit;
            it_idx_reg   <= in_idx;
            it_last_reg  <= items.last_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_CLEAR;
            epoch_reg    <= EPOCH_FIRST;
            fresh_reg    <= 1'b1;
            clr_addr_reg <= '0;
            cnt_reg      <= '0;
            matched_reg  <= 1'b0;
            mlead_reg    <= '0;
            ovf_reg      <= 1'b0;
            wb_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + HIDX_W'(1);
                if (clr_addr_reg == '1)
                begin
                    epoch_reg <= EPOCH_FIRST;
                    fresh_reg <= 1'b1;
                end
            end
            if (fire)
            begin
                fresh_reg <= 1'b0;
                if (items.new_event)
                begin
                    if (!fresh_reg)
                    begin
                        epoch_reg <= epoch_reg + epoch_t'(1);
                    end
                    cnt_reg     <= '0;
                    matched_reg <= 1'b0;
                    mlead_reg   <= '0;
                    ovf_reg     <= 1'b0;
                end
            end
            if (state_reg == F_LOOK)
            begin
                if (it_last_reg)
                begin
                    cnt_reg     <= '0;
                    matched_reg <= 1'b0;
                    mlead_reg   <= '0;
                    ovf_reg     <= 1'b0;
                end
                else
                begin
                    cnt_reg     <= cnt_next;
                    matched_reg <= matched_next;
                    mlead_reg   <= mlead_next;
                    ovf_reg     <= ovf_next;
                end
            end
            if (push && !matched_next)
            begin
                wb_pend_reg <= 1'b1;
            end
            else if (wb_done)
            begin
                wb_pend_reg <= 1'b0;
            end
        end
    end

    // No lookup may start while a new cluster is still being written back.
    a_no_fire_during_wb: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> !wb_pend_reg)
        else $error("hit accepted while write-back pending");

    // The pending count never exceeds the buffer depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_FULL)
        else $error("pending count beyond buffer depth");

    // The tag reserved for cleared entries is never the live one.
    a_epoch_live: assert property (@(posedge clk) disable iff (!rst_n)
        epoch_reg != EPOCH_NONE)
        else $error("live event tag equals cleared tag");
endmodule

// File: rtl/shc_back.sv
// ----------------------------------------------------------------------------
// Clustering back
// Takes classified jobs, writes the buffered hits of new clusters into the
// hit table and presents the result transaction from an output register.
// ----------------------------------------------------------------------------
module shc_back
    import shc_pkg::*;
#(
    parameter int HIT_ID_SPACE = 65536,
    parameter int MAX_HITS     = 32
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  pend_wr_t  pend_wr,
    input  logic      q_avail,
    input  job_t      q_head,
    output logic      q_pop,
    output tbl_wr_t   upd_wr,
    output logic      wb_done,
    shc_res_if.source results
);
    localparam int HIDX_W = $clog2(HIT_ID_SPACE);
    localparam int CNT_W  = $clog2(MAX_HITS + 1);
    localparam int PIDX_W = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;

    logic [HIDX_W-1:0]  pend_mem [MAX_HITS];
    back_state_t        state_reg, state_next;
    job_t               job_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               rdv_reg;
    logic [HIDX_W-1:0]  rd_hit_reg;
    logic               out_vld_reg;
    job_t               out_reg;

    logic               has_writes;
    logic               issue;
    logic               finish;
    logic               load_out;

    assign q_pop      = q_avail && (state_reg == B_IDLE) && (!out_vld_reg || results.ready);
    assign has_writes = q_head.new_cluster && (q_head.count != '0);
    assign issue      = (state_reg == B_WRITE) && (CNT_MAX_W'(idx_reg) < job_reg.count);
    assign finish     = (state_reg == B_WRITE) && !issue && !rdv_reg;
    assign load_out   = (q_pop && !has_writes) || finish;
    assign wb_done    = (q_pop && q_head.new_cluster && !has_writes) || finish;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_pop && has_writes)
                begin
                    state_next = B_WRITE;
                end
            end
            B_WRITE:
            begin
                if (finish)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        upd_wr.en     = rdv_reg;
        upd_wr.addr   = HADDR_MAX_W'(rd_hit_reg);
        upd_wr.epoch  = job_reg.epoch;
        upd_wr.leader = job_reg.track;
    end

    assign results.valid        = out_vld_reg;
    assign results.track_id_out = out_reg.track;
    assign results.leader_id    = out_reg.leader;
    assign results.new_cluster  = out_reg.new_cluster;
    assign results.overflow     = out_reg.overflow;

    always_ff @(posedge clk)
    begin
        if (pend_wr.en)
        begin
            pend_mem[pend_wr.addr[PIDX_W-1:0]] <= pend_wr.hit[HIDX_W-1:0];
        end
        if (issue)
        begin
            rd_hit_reg <= pend_mem[idx_reg[PIDX_W-1:0]];
        end
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        if (load_out)
        begin
            out_reg <= finish ? job_reg : q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_IDLE;
            idx_reg     <= '0;
            rdv_reg     <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg   <= issue;
            if (q_pop)
            begin
                idx_reg <= '0;
            end
            else if (issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Table writes happen only while a new cluster is being written back.
    a_wr_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        upd_wr.en |-> (state_reg == B_WRITE))
        else $error("table write outside write-back");

    // A finished write-back loads its result only into an empty output register.
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        finish |-> !out_vld_reg)
        else $error("write-back finished with output occupied");

    // Only new clusters are written back.
    a_wr_new: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_WRITE) |-> job_reg.new_cluster)
        else $error("write-back of a joined track");
endmodule

// File: rtl/shared_hit_track_clustering.sv
// ----------------------------------------------------------------------------
// Shared-hit track clustering
// Greedy clustering of tracks by shared hits, one result per track.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Transaction           Produced
//  items     in   one hit of a track    every hit, or one item for a hitless track
//  results   out  one classified track  on the item with last_hit set
//
//  An item reads the hit table and is classified in the cycle after; the
//  next item is taken only once the front is idle again. A track that
//  starts a new cluster holds off the next item until its buffered hits
//  are in the table (one table write port), one write per buffered hit.
//  The write-back waits for a free output register, not for its own
//  result to be taken.
//  After reset, and when a new event arrives after all 255 event tags are
//  used, a clearing sweep runs through all HIT_ID_SPACE table entries
//  while items are held off. A stalled result sits in the output register;
//  two more tracks queue behind it before the input stalls.
//
module shared_hit_track_clustering
    import shc_pkg::*;
#(
    parameter int HIT_ID_SPACE  = 65536,
    parameter int MAX_HITS      = 32,
    parameter int TRACK_ID_BITS = 16
)
(
    input logic       clk,
    input logic       rst_n,
    shc_hit_if.sink   items,
    shc_res_if.source results
);
    localparam int HIDX_W = $clog2(HIT_ID_SPACE);

    // Table index is the low bits of the hit id (HIT_ID_SPACE a power of two).
    logic               tbl_rd_en;
    logic [HIDX_W-1:0]  tbl_rd_addr;
    epoch_t             tbl_rd_epoch;
    logic [TRACK_W-1:0] tbl_rd_leader;
    tbl_wr_t            clr_wr;
    tbl_wr_t            upd_wr;
    pend_wr_t           pend_wr;
    logic               push;
    job_t               push_job;
    logic               q_full;
    logic               q_avail;
    job_t               q_head;
    logic               q_pop;
    logic               wb_done;

    // The front classifies each track from table lookups.
    shc_front #(
        .HIT_ID_SPACE  (HIT_ID_SPACE),
        .MAX_HITS      (MAX_HITS),
        .TRACK_ID_BITS (TRACK_ID_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .items         (items),
        .tbl_rd_en     (tbl_rd_en),
        .tbl_rd_addr   (tbl_rd_addr),
        .tbl_rd_epoch  (tbl_rd_epoch),
        .tbl_rd_leader (tbl_rd_leader),
        .clr_wr        (clr_wr),
        .pend_wr       (pend_wr),
        .push          (push),
        .push_job      (push_job),
        .q_full        (q_full),
        .wb_done       (wb_done)
    );

    // Classified tracks wait here so the front can move on.
    shc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .avail    (q_avail),
        .head     (q_head),
        .pop      (q_pop)
    );

    // The back writes new clusters into the table and drives the results.
    shc_back #(
        .HIT_ID_SPACE (HIT_ID_SPACE),
        .MAX_HITS     (MAX_HITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .pend_wr (pend_wr),
        .q_avail (q_avail),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .upd_wr  (upd_wr),
        .wb_done (wb_done),
        .results (results)
    );

    // Entries whose event tag differs from the live tag count as absent.
    shc_table #(
        .HIT_ID_SPACE  (HIT_ID_SPACE),
        .TRACK_ID_BITS (TRACK_ID_BITS)
    ) u_table (
        .clk       (clk),
        .clr_wr    (clr_wr),
        .upd_wr    (upd_wr),
        .rd_en     (tbl_rd_en),
        .rd_addr   (tbl_rd_addr),
        .rd_epoch  (tbl_rd_epoch),
        .rd_leader (tbl_rd_leader)
    );
endmodule
